/* rtl/core/dtbs_pkg.sv */
// Shared types, widths and constants for the best split search block.
// Used by dtbs_div, dtbs_mul and decision_tree_best_split_search.
// No dependencies.
package dtbs_pkg;

  localparam int VALUE_W   = 32;
  localparam int WEIGHT_W  = 32;
  localparam int ACC_W     = 48;
  localparam int NODE_W    = 49;
  localparam int FRAC_W    = 33;
  localparam int DIV_STEPS = 32;
  localparam int MUL_A_W   = 33;
  localparam int MUL_B_W   = 37;
  localparam int MUL_R_W   = MUL_A_W + MUL_B_W - 32;
  localparam int IMP_W     = 34;
  localparam int GAIN_W    = 35;
  localparam int LNW_W     = 37;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 72;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  localparam int LOG_TABLE_DEPTH_DEF = 1024;

  localparam logic [FRAC_W-1:0] FRAC_ONE = {1'b1, {(FRAC_W-1){1'b0}}};
  localparam logic [LNW_W-1:0]  LN2_Q32  = LNW_W'(64'd2977044472);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_TARGET  = 2'd1;
  localparam logic [1:0] REG_OUTLIER = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START,
    ST_CHILD,
    ST_CF_WAIT,
    ST_IMP,
    ST_P_WAIT,
    ST_TERM,
    ST_NORM,
    ST_LN,
    ST_M_WAIT,
    ST_ACC,
    ST_RET,
    ST_WM_WAIT,
    ST_JUDGE,
    ST_UPD,
    ST_EMIT
  } dtbs_state_t;

  // Odd power series of atanh, giving ln(1+x) from z = x/(2+x).
  function automatic logic [31:0] ln_series(input longint unsigned z);
    longint unsigned z2;
    longint unsigned t;
    longint unsigned s;
    z2 = (z * z) >> 32;
    t = z;
    s = z;
    t = (t * z2) >> 32; s += t / 3;
    t = (t * z2) >> 32; s += t / 5;
    t = (t * z2) >> 32; s += t / 7;
    t = (t * z2) >> 32; s += t / 9;
    t = (t * z2) >> 32; s += t / 11;
    t = (t * z2) >> 32; s += t / 13;
    t = (t * z2) >> 32; s += t / 15;
    t = (t * z2) >> 32; s += t / 17;
    t = (t * z2) >> 32; s += t / 19;
    t = (t * z2) >> 32; s += t / 21;
    t = (t * z2) >> 32; s += t / 23;
    t = (t * z2) >> 32; s += t / 25;
    t = (t * z2) >> 32; s += t / 27;
    t = (t * z2) >> 32; s += t / 29;
    t = (t * z2) >> 32; s += t / 31;
    ln_series = 32'(s << 1);
  endfunction

endpackage

/* rtl/core/decision_tree_best_split_search.sv */
// Top level of the best numeric split search for a two-class tree node.
// Depends on dtbs_pkg, dtbs_div and dtbs_mul.
//
//   Channel  Direction  Carries
//   in_      slave      one sample: value, weight (tdata), class (tuser), last (tlast)
//   out_     master     one result per node: found, best gain, best split (tdata)
//   cfg_     APB        impurity mode and the two 48-bit class totals, on a 64-bit bus
//
// Scoring a split uses the single bit-serial divider and the bit-serial multiplier,
// shared by all six fractions and their products. The first sample of a node
// computes one parent impurity instead of scoring a split.
// Reset is synchronous and active low; it clears control state and the configuration registers.
// A finished result waits in the output register while the next sample is
// taken; the block stalls only if a second result is due before it is taken.
module decision_tree_best_split_search #(
  parameter int LOG_TABLE_DEPTH = dtbs_pkg::LOG_TABLE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: sample_value [31:0], sample_weight [63:32]
  input  logic [dtbs_pkg::IN_DATA_W-1:0]    in_tdata,
  // tuser: class_label [0]
  input  logic                              in_tuser,
  input  logic                              in_tlast,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: split_found [0], best_gain [32:1], best_split [64:33], zero pad above
  output logic [dtbs_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [dtbs_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [dtbs_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [dtbs_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);
  import dtbs_pkg::*;

  localparam int LN_AW = $clog2(LOG_TABLE_DEPTH);

  // Configuration registers.
  logic              mode_r;
  logic [ACC_W-1:0]  tot0_r;
  logic [ACC_W-1:0]  tot1_r;
  logic [1:0]        cfg_idx;
  logic              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:3];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      tot0_r <= '0;
      tot1_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:    mode_r <= cfg_pwdata[0];
        REG_TARGET:  tot0_r <= cfg_pwdata[ACC_W-1:0];
        REG_OUTLIER: tot1_r <= cfg_pwdata[ACC_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:    cfg_prdata = CFG_DATA_W'(mode_r);
      REG_TARGET:  cfg_prdata = CFG_DATA_W'(tot0_r);
      REG_OUTLIER: cfg_prdata = CFG_DATA_W'(tot1_r);
      default:     cfg_prdata = '0;
    endcase
  end

  // Constant table of ln(1 + i/depth) in Q0.32 with a registered read.
  logic [31:0] ln_tab [LOG_TABLE_DEPTH];

  for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++) begin : g_ln
    localparam longint unsigned LnZ =
      (64'(gi) << 32) / (64'(2 * LOG_TABLE_DEPTH + gi));
    assign ln_tab[gi] = ln_series(LnZ);
  end

  // Sequencer and datapath registers.
  dtbs_state_t state_r, state_nxt;

  logic signed [VALUE_W-1:0] val_r;
  logic signed [VALUE_W-1:0] prev_r;
  logic [WEIGHT_W-1:0]       w_r;
  logic                      cls_r;
  logic                      last_r;
  logic                      first_r;
  logic [ACC_W-1:0]          lw0_r, lw1_r, lsum_r;
  logic [ACC_W-1:0]          rw0_r, rw1_r;
  logic [NODE_W-1:0]         rsum_r;
  logic [NODE_W-1:0]         node_r;
  logic [IMP_W-1:0]          parent_r;
  logic [GAIN_W-1:0]         best_r;
  logic [VALUE_W-1:0]        split_r;
  logic                      found_r;
  logic                      in_parent_r;
  logic                      child_r;
  logic                      ic_r;
  logic [ACC_W-1:0]          iw0_r, iw1_r;
  logic [NODE_W-1:0]         itot_r;
  logic [FRAC_W-1:0]         p_r;
  logic [31:0]               pn_r;
  logic [LNW_W-1:0]          whole_r;
  logic [31:0]               rom_q_r;
  logic [MUL_R_W-1:0]        term_r;
  logic [IMP_W-1:0]          acc_r;
  logic [FRAC_W-1:0]         f_r;
  logic [GAIN_W-1:0]         wsum_r;
  logic                      out_valid_r;
  logic                      out_found_r;
  logic [31:0]               out_gain_r;
  logic [VALUE_W-1:0]        out_split_r;

  logic                 div_start, div_done;
  logic [NODE_W-1:0]    div_num, div_den;
  logic [FRAC_W-1:0]    div_quo;
  logic                 mul_start, mul_done;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [MUL_R_W-1:0]   mul_res;

  logic                 in_acc;
  logic [NODE_W-1:0]    child_tot;
  logic [NODE_W-1:0]    node_sum;
  logic                 rise;
  logic [GAIN_W-1:0]    parent_ext;
  logic [GAIN_W-1:0]    gain;
  logic [VALUE_W:0]     diff;
  logic [ACC_W:0]       sum0, sum1, sumt;

  dtbs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  dtbs_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  assign in_acc     = in_tvalid & in_tready;
  assign child_tot  = child_r ? rsum_r : {1'b0, lsum_r};
  assign node_sum   = {1'b0, tot0_r} + {1'b0, tot1_r};
  assign rise       = val_r > prev_r;
  assign parent_ext = GAIN_W'(parent_r);
  assign gain       = parent_ext - wsum_r;
  assign diff       = {val_r[VALUE_W-1], val_r} - {prev_r[VALUE_W-1], prev_r};
  assign sum0       = {1'b0, lw0_r} + {{(ACC_W-WEIGHT_W+1){1'b0}}, w_r};
  assign sum1       = {1'b0, lw1_r} + {{(ACC_W-WEIGHT_W+1){1'b0}}, w_r};
  assign sumt       = {1'b0, lsum_r} + {{(ACC_W-WEIGHT_W+1){1'b0}}, w_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state, handshake and launches of the shared serial units.
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = itot_r;
    mul_start = 1'b0;
    mul_a     = p_r;
    mul_b     = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = ST_START;
      end
      ST_START: begin
        if (first_r) state_nxt = ST_IMP;
        else if (rise) state_nxt = ST_CHILD;
        else state_nxt = ST_UPD;
      end
      ST_CHILD: begin
        if (node_r == '0 || child_tot == '0) begin
          if (child_r) state_nxt = ST_JUDGE;
        end else begin
          div_start = 1'b1;
          div_num   = child_tot;
          div_den   = node_r;
          state_nxt = ST_CF_WAIT;
        end
      end
      ST_CF_WAIT: begin
        if (div_done) state_nxt = ST_IMP;
      end
      ST_IMP: begin
        if (itot_r == '0) begin
          state_nxt = ST_RET;
        end else begin
          div_start = 1'b1;
          div_num   = {1'b0, iw0_r};
          state_nxt = ST_P_WAIT;
        end
      end
      ST_P_WAIT: begin
        if (div_done) state_nxt = ST_TERM;
      end
      ST_TERM: begin
        if (mode_r) begin
          mul_start = 1'b1;
          mul_b     = MUL_B_W'(FRAC_ONE - p_r);
          state_nxt = ST_M_WAIT;
        end else if (p_r == '0 || p_r[FRAC_W-1]) begin
          state_nxt = ST_ACC;
        end else begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        if (pn_r[31]) state_nxt = ST_LN;
      end
      ST_LN: begin
        if (whole_r <= LNW_W'(rom_q_r)) begin
          state_nxt = ST_ACC;
        end else begin
          mul_start = 1'b1;
          mul_b     = whole_r - LNW_W'(rom_q_r);
          state_nxt = ST_M_WAIT;
        end
      end
      ST_M_WAIT: begin
        if (mul_done) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (ic_r) begin
          state_nxt = ST_RET;
        end else begin
          div_start = 1'b1;
          div_num   = {1'b0, iw1_r};
          state_nxt = ST_P_WAIT;
        end
      end
      ST_RET: begin
        if (in_parent_r) begin
          state_nxt = ST_UPD;
        end else begin
          mul_start = 1'b1;
          mul_a     = f_r;
          mul_b     = MUL_B_W'(acc_r);
          state_nxt = ST_WM_WAIT;
        end
      end
      ST_WM_WAIT: begin
        if (mul_done) state_nxt = child_r ? ST_JUDGE : ST_CHILD;
      end
      ST_JUDGE: state_nxt = ST_UPD;
      ST_UPD:   state_nxt = last_r ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == ST_UPD) first_r <= last_r;
      if (state_r == ST_EMIT && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    rom_q_r <= ln_tab[pn_r[30 -: LN_AW]];
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          val_r  <= in_tdata[VALUE_W-1:0];
          w_r    <= in_tdata[IN_DATA_W-1:VALUE_W];
          cls_r  <= in_tuser;
          last_r <= in_tlast;
        end
      end
      ST_START: begin
        if (first_r) begin
          node_r      <= node_sum;
          iw0_r       <= tot0_r;
          iw1_r       <= tot1_r;
          itot_r      <= node_sum;
          in_parent_r <= 1'b1;
          lw0_r       <= '0;
          lw1_r       <= '0;
          lsum_r      <= '0;
          best_r      <= '0;
          split_r     <= '0;
          found_r     <= 1'b0;
        end else begin
          rw0_r   <= (tot0_r > lw0_r) ? tot0_r - lw0_r : '0;
          rw1_r   <= (tot1_r > lw1_r) ? tot1_r - lw1_r : '0;
          rsum_r  <= ((tot0_r > lw0_r) ? {1'b0, tot0_r - lw0_r} : '0) +
                     ((tot1_r > lw1_r) ? {1'b0, tot1_r - lw1_r} : '0);
          wsum_r  <= '0;
          child_r <= 1'b0;
        end
      end
      ST_CHILD: begin
        in_parent_r <= 1'b0;
        iw0_r       <= child_r ? rw0_r : lw0_r;
        iw1_r       <= child_r ? rw1_r : lw1_r;
        itot_r      <= child_tot;
        if ((node_r == '0 || child_tot == '0) && !child_r) child_r <= 1'b1;
      end
      ST_CF_WAIT: begin
        if (div_done) f_r <= div_quo;
      end
      ST_IMP: begin
        acc_r <= '0;
        ic_r  <= 1'b0;
      end
      ST_P_WAIT: begin
        if (div_done) p_r <= div_quo;
      end
      ST_TERM: begin
        term_r  <= '0;
        pn_r    <= p_r[31:0];
        whole_r <= LN2_Q32;
      end
      ST_NORM: begin
        if (!pn_r[31]) begin
          pn_r    <= {pn_r[30:0], 1'b0};
          whole_r <= whole_r + LN2_Q32;
        end
      end
      ST_LN:   term_r <= '0;
      ST_M_WAIT: begin
        if (mul_done) term_r <= mul_res;
      end
      ST_ACC: begin
        acc_r <= acc_r + IMP_W'(term_r);
        ic_r  <= 1'b1;
      end
      ST_RET: begin
        if (in_parent_r) parent_r <= acc_r;
      end
      ST_WM_WAIT: begin
        if (mul_done) begin
          wsum_r <= wsum_r + GAIN_W'(mul_res);
          if (!child_r) child_r <= 1'b1;
        end
      end
      ST_JUDGE: begin
        // Only a strictly larger positive gain replaces the kept split.
        if (parent_ext > wsum_r && gain > best_r) begin
          best_r  <= gain;
          found_r <= 1'b1;
          split_r <= prev_r + diff[VALUE_W:1];
        end
      end
      ST_UPD: begin
        prev_r <= val_r;
        lsum_r <= sumt[ACC_W] ? '1 : sumt[ACC_W-1:0];
        if (cls_r) lw1_r <= sum1[ACC_W] ? '1 : sum1[ACC_W-1:0];
        else lw0_r <= sum0[ACC_W] ? '1 : sum0[ACC_W-1:0];
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_found_r <= found_r;
          out_gain_r  <= best_r[31:0];
          out_split_r <= split_r;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-2*32-1){1'b0}}, out_split_r, out_gain_r, out_found_r};
endmodule

/* rtl/core/dtbs_div.sv */
// Bit-serial restoring divider giving an unsigned Q1.32 fraction num/den, saturated at one.
// Depends on dtbs_pkg.
module dtbs_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [dtbs_pkg::NODE_W-1:0]  num,
  input  logic [dtbs_pkg::NODE_W-1:0]  den,
  output logic                         done,
  output logic [dtbs_pkg::FRAC_W-1:0]  quo
);
  import dtbs_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [NODE_W-1:0] rem_r;
  logic [NODE_W-1:0] den_r;
  logic [FRAC_W-1:0] quo_r;
  logic [NODE_W:0]   rem2;
  logic              fits;
  logic [NODE_W-1:0] rem_nxt;

  always_comb begin
    rem2    = {rem_r, 1'b0};
    fits    = rem2 >= {1'b0, den_r};
    rem_nxt = fits ? NODE_W'(rem2 - {1'b0, den_r}) : rem2[NODE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        den_r <= den;
        if (den == '0) begin
          quo_r  <= '0;
          done_r <= 1'b1;
        end else if (num >= den) begin
          quo_r  <= FRAC_ONE;
          done_r <= 1'b1;
        end else begin
          rem_r  <= num;
          quo_r  <= '0;
          cnt_r  <= CNT_W'(DIV_STEPS);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[FRAC_W-2:0], fits};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
endmodule

/* rtl/core/dtbs_mul.sv */
// Bit-serial shift-and-add multiplier returning the product shifted right by 32.
// Depends on dtbs_pkg.
module dtbs_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dtbs_pkg::MUL_A_W-1:0]  a,
  input  logic [dtbs_pkg::MUL_B_W-1:0]  b,
  output logic                          done,
  output logic [dtbs_pkg::MUL_R_W-1:0]  res
);
  import dtbs_pkg::*;

  localparam int P_W   = MUL_A_W + MUL_B_W;
  localparam int CNT_W = $clog2(MUL_B_W + 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [MUL_A_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [P_W-1:0]     acc_r;
  logic [P_W-1:0]     acc_nxt;

  // Multiplier bits are taken from the top down.
  always_comb begin
    acc_nxt = {acc_r[P_W-2:0], 1'b0} +
              (b_r[MUL_B_W-1] ? P_W'(a_r) : P_W'(0));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        a_r    <= a;
        b_r    <= b;
        acc_r  <= '0;
        cnt_r  <= CNT_W'(MUL_B_W);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        b_r   <= {b_r[MUL_B_W-2:0], 1'b0};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign res  = acc_r[P_W-1:32];
endmodule
